// ===== rtl/core/bdkr_pkg.sv =====
// Shared types and constants for the button debounce / key repeat unit.
`timescale 1ns / 1ps

package bdkr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [15:0] FIRST_REP_RST  = 16'd500;
  localparam logic [15:0] SECOND_REP_RST = 16'd100;
  localparam logic [15:0] STEP_RST       = 16'd5;
  localparam logic [15:0] MIN_REP_RST    = 16'd30;
  localparam logic [31:0] PIN_MASK_RST   = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_FIRST_REP  = 3'd1,
    CFG_SECOND_REP = 3'd2,
    CFG_STEP       = 3'd3,
    CFG_MIN_REP    = 3'd4,
    CFG_PIN_MASK   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_REPEAT  = 2'd2
  } kind_e;

  typedef enum logic {
    MODE_TICK   = 1'b0,
    MODE_CHANGE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] first_rep;
    logic [15:0] second_rep;
    logic [15:0] step;
    logic [15:0] min_rep;
    logic [31:0] pin_mask;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    logic       is_change;
    logic [4:0] pin;
    logic       pressed;
  } cmd_t;

endpackage

// ===== rtl/core/bdkr_front.sv =====
// Input front end: decodes input words and drops changes on disabled or nonexistent pins.
`timescale 1ns / 1ps

module bdkr_front #(
  parameter int unsigned NUM_PINS = 32
) (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic [31:0]       pin_mask_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output bdkr_pkg::cmd_t    q_cmd_o
);

  logic [4:0] pin;
  logic       is_change;
  logic       keep;

  assign pin       = s_axis_tdata[4:0];
  assign is_change = (s_axis_tuser == bdkr_pkg::MODE_CHANGE);

  // ticks always pass; a change passes only on an enabled, existing pin
  assign keep = !is_change || ((32'(pin) < NUM_PINS) && pin_mask_i[pin]);

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && keep;

  assign q_cmd_o.is_change = is_change;
  assign q_cmd_o.pin       = pin;
  assign q_cmd_o.pressed   = s_axis_tdata[5];

endmodule

// ===== rtl/core/bdkr_fifo.sv =====
// Short command queue between the front end and the event engine.
`timescale 1ns / 1ps

module bdkr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bdkr_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bdkr_pkg::cmd_t cmd_o
);

  localparam int unsigned AW = bdkr_pkg::QUEUE_AW;
  localparam int unsigned DEPTH = bdkr_pkg::QUEUE_DEPTH;

  bdkr_pkg::cmd_t      mem_q [DEPTH];
  logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [AW:0]         count_q, count_d;
  logic                do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/bdkr_back.sv =====
// Event engine: debounce timing, pin scan, key repeat and output register.
`timescale 1ns / 1ps

module bdkr_back #(
  parameter int unsigned NUM_PINS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bdkr_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  bdkr_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,
  output logic           m_axis_tlast
);

  localparam int unsigned NP = (NUM_PINS < 32) ? NUM_PINS : 32;
  localparam int unsigned IW = (NP > 1) ? $clog2(NP) : 1;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_DEBOUNCE  = 2'd1,
    PH_REP_FIRST = 2'd2,
    PH_REP_MORE  = 2'd3
  } phase_e;

  typedef enum logic {
    ST_RUN,
    ST_SCAN
  } state_e;

  state_e          state_q;
  phase_e          phase_q;
  logic [NP-1:0]   raw_q;
  logic [NP-1:0]   reported_q;
  logic [NP-1:0]   rem_q;
  logic [IW-1:0]   idx_q;
  logic [4:0]      rep_pin_q;
  logic            rep_active_q;
  logic [15:0]     interval_q;
  logic [15:0]     elapsed_q;

  logic            out_valid_q;
  logic [4:0]      out_pin_q;
  logic [1:0]      out_kind_q;
  logic            out_last_q;

  logic            out_free;
  logic [15:0]     elapsed_inc;
  logic [NP-1:0]   rem_cleared;
  logic            scan_last;
  logic [15:0]     shrunk;
  logic            rep_due;
  logic            scan_emit;
  logic            out_fire;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign shrunk      = (interval_q > cfg_i.step) ? interval_q - cfg_i.step : 16'd0;

  always_comb begin
    rem_cleared        = rem_q;
    rem_cleared[idx_q] = 1'b0;
  end
  assign scan_last = (rem_cleared == '0);

  // commands are consumed only in the run state; a due repeat waits for a free slot
  always_comb begin
    cmd_pop_o = 1'b0;
    if (state_q == ST_RUN && cmd_valid_i) begin
      if (cmd_i.is_change || phase_q == PH_IDLE || phase_q == PH_DEBOUNCE
          || !rep_active_q || elapsed_inc < interval_q || out_free) begin
        cmd_pop_o = 1'b1;
      end
    end
  end

  // a new word enters the output register on a due repeat or a scanned pin
  assign rep_due   = (state_q == ST_RUN) && cmd_pop_o && !cmd_i.is_change
                     && (phase_q == PH_REP_FIRST || phase_q == PH_REP_MORE)
                     && rep_active_q && !(elapsed_inc < interval_q);
  assign scan_emit = (state_q == ST_SCAN) && rem_q[idx_q] && out_free;
  assign out_fire  = rep_due || scan_emit;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_kind_q, out_pin_q};
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      phase_q      <= PH_IDLE;
      raw_q        <= '0;
      reported_q   <= '0;
      rem_q        <= '0;
      idx_q        <= '0;
      rep_pin_q    <= '0;
      rep_active_q <= 1'b0;
      interval_q   <= '0;
      elapsed_q    <= '0;
      out_valid_q  <= 1'b0;
      out_pin_q    <= '0;
      out_kind_q   <= bdkr_pkg::KIND_RELEASE;
      out_last_q   <= 1'b0;
    end else begin
      out_valid_q <= out_fire || (out_valid_q && !m_axis_tready);
      unique case (state_q)
        ST_RUN: begin
          if (cmd_pop_o) begin
            if (cmd_i.is_change) begin
              raw_q[cmd_i.pin[IW-1:0]] <= cmd_i.pressed;
              phase_q   <= PH_DEBOUNCE;
              elapsed_q <= '0;
            end else begin
              unique case (phase_q)
                PH_DEBOUNCE: begin
                  if (elapsed_inc >= cfg_i.debounce) begin
                    rem_q      <= raw_q ^ reported_q;
                    reported_q <= raw_q;
                    phase_q    <= PH_IDLE;
                    elapsed_q  <= '0;
                    idx_q      <= '0;
                    state_q    <= ST_SCAN;
                  end else begin
                    elapsed_q <= elapsed_inc;
                  end
                end
                PH_REP_FIRST, PH_REP_MORE: begin
                  if (!rep_active_q) begin
                    phase_q <= PH_IDLE;
                  end else if (elapsed_inc < interval_q) begin
                    elapsed_q <= elapsed_inc;
                  end else begin
                    out_pin_q   <= rep_pin_q;
                    out_kind_q  <= bdkr_pkg::KIND_REPEAT;
                    out_last_q  <= 1'b1;
                    elapsed_q   <= '0;
                    if (phase_q == PH_REP_FIRST) begin
                      phase_q    <= PH_REP_MORE;
                      interval_q <= cfg_i.second_rep;
                    end else if (interval_q > cfg_i.min_rep) begin
                      interval_q <= shrunk;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (rem_q == '0) begin
            state_q <= ST_RUN;
          end else if (rem_q[idx_q]) begin
            if (out_free) begin
              out_pin_q   <= 5'(idx_q);
              out_last_q  <= scan_last;
              rem_q       <= rem_cleared;
              if (raw_q[idx_q]) begin
                out_kind_q   <= bdkr_pkg::KIND_PRESS;
                rep_pin_q    <= 5'(idx_q);
                rep_active_q <= 1'b1;
                phase_q      <= PH_REP_FIRST;
                interval_q   <= cfg_i.first_rep;
              end else begin
                out_kind_q   <= bdkr_pkg::KIND_RELEASE;
                rep_active_q <= 1'b0;
                phase_q      <= PH_IDLE;
              end
              if (scan_last) begin
                state_q <= ST_RUN;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/button_debounce_key_repeat_unit.sv =====
// Top level of the button debounce / key repeat unit.
`timescale 1ns / 1ps

// Takes pin level changes and millisecond ticks as input words and emits key
// events (release, press, repeat) as output words, tlast marking the final
// event of a batch. Input words land in a four-entry command queue; the event
// engine behind it pops them in order, but pops none during a pin scan and
// holds a tick that makes a repeat due until the output register is free.
// A tick that ends the debounce wait starts a pin scan that walks one pin per
// cycle, waiting at a changed pin while tready is low. Configuration writes
// are taken at any time and should be made only while the unit is idle.
module button_debounce_key_repeat_unit #(
  parameter int unsigned NUM_PINS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] pin, [5] pressed, [7:6] zero
  input  logic        s_axis_tuser,   // [0] mode: 0 tick, 1 pin change
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [4:0] event_pin, [6:5] event_kind, [7] zero
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [bdkr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bdkr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  bdkr_pkg::cfg_t cfg_q;
  bdkr_pkg::cmd_t push_cmd;
  bdkr_pkg::cmd_t pop_cmd;
  logic           q_full;
  logic           q_push;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= bdkr_pkg::DEBOUNCE_RST;
      cfg_q.first_rep  <= bdkr_pkg::FIRST_REP_RST;
      cfg_q.second_rep <= bdkr_pkg::SECOND_REP_RST;
      cfg_q.step       <= bdkr_pkg::STEP_RST;
      cfg_q.min_rep    <= bdkr_pkg::MIN_REP_RST;
      cfg_q.pin_mask   <= bdkr_pkg::PIN_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdkr_pkg::CFG_DEBOUNCE:   cfg_q.debounce   <= cfg_wdata_i[15:0];
        bdkr_pkg::CFG_FIRST_REP:  cfg_q.first_rep  <= cfg_wdata_i[15:0];
        bdkr_pkg::CFG_SECOND_REP: cfg_q.second_rep <= cfg_wdata_i[15:0];
        bdkr_pkg::CFG_STEP:       cfg_q.step       <= cfg_wdata_i[15:0];
        bdkr_pkg::CFG_MIN_REP:    cfg_q.min_rep    <= cfg_wdata_i[15:0];
        bdkr_pkg::CFG_PIN_MASK:   cfg_q.pin_mask   <= cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  bdkr_front #(
    .NUM_PINS(NUM_PINS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .pin_mask_i   (cfg_q.pin_mask),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  bdkr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (pop_cmd)
  );

  bdkr_back #(
    .NUM_PINS(NUM_PINS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (q_valid),
    .cmd_i        (pop_cmd),
    .cmd_pop_o    (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== rtl/core/bdkr_checker.sv =====
// Port-level checks for the button debounce / key repeat unit, with its bind.
`timescale 1ns / 1ps

module bdkr_checker #(
  parameter int unsigned NUM_PINS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_repeat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6:5] == bdkr_pkg::KIND_REPEAT |-> m_axis_tlast)
    else $error("repeat event without tlast");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6:5] != 2'd3 && !m_axis_tdata[7])
    else $error("illegal event kind or pad bit");

  a_pin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[4:0]) < NUM_PINS)
    else $error("event pin out of range");

endmodule

bind button_debounce_key_repeat_unit bdkr_checker #(
  .NUM_PINS(NUM_PINS)
) u_bdkr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
